// ----- rtl/core/onewire_bit_master_top_assert.svh -----
// ----------------------------------------------------------------------------
// onewire_bit_master_top_assert.svh
// Assertion macros for the 1-Wire bit engine.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_BIT_MASTER_TOP_ASSERT_SVH
`define ONEWIRE_BIT_MASTER_TOP_ASSERT_SVH

// Implication checked on every edge out of reset.
`define OWB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Plain condition checked on every edge out of reset.
`define OWB_ASSERT_COND(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`endif

// ----- rtl/core/owb_pkg.sv -----
// ----------------------------------------------------------------------------
// owb_pkg
// Types, register indexes and reset values for the 1-Wire bit engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owb_pkg;

   localparam int TIME_W  = 10;
   localparam int NUM_REGS = 8;
   localparam int CSR_IDX_W = 8;

   localparam logic [TIME_W-1:0] RECOVERY_TIME_DEF = TIME_W'(410);

   typedef logic [TIME_W-1:0] time_type;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_RESET = 3'd1,
      CMD_W0    = 3'd2,
      CMD_W1    = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      OP_RESET = 2'd0,
      OP_W0    = 2'd1,
      OP_W1    = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LOW  = 2'd1,
      PH_WAIT = 2'd2,
      PH_TAIL = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      REG_W1_LOW   = 3'd0,
      REG_W1_REL   = 3'd1,
      REG_W0_LOW   = 3'd2,
      REG_W0_REL   = 3'd3,
      REG_RD_SAMP  = 3'd4,
      REG_RD_TAIL  = 3'd5,
      REG_RST_LOW  = 3'd6,
      REG_PRES_SMP = 3'd7
   } reg_idx_type;

   localparam time_type REG_RESET_VALS [NUM_REGS] = '{
      TIME_W'(6), TIME_W'(64), TIME_W'(60), TIME_W'(10),
      TIME_W'(9), TIME_W'(55), TIME_W'(480), TIME_W'(70)
   };

   // a zero time counts as one tick
   function automatic time_type ticks_of(input time_type v);
      return (v == '0) ? TIME_W'(1) : v;
   endfunction

endpackage

// ----- rtl/core/onewire_bit_master_top.sv -----
// ----------------------------------------------------------------------------
// onewire_bit_master_top
// 1-Wire master bit engine: slot timing for reset/presence, write and read.
// ----------------------------------------------------------------------------
// Request beats carry a command: a 1 us tick, or the start of a reset,
// write-zero, write-one or read slot, together with the sampled bus level.
// Every request beat yields exactly one response beat giving the drive_low
// and busy state after the beat, plus done, read bit, presence and rejected.
// The response is registered, valid the cycle after its beat; one beat is
// taken every cycle while the response side keeps up. The response register
// frees itself in the same cycle it is taken, so req_ready only falls while
// a response is held by a stalled receiver; nothing is dropped.
// The csr channel writes the eight slot timing registers, always ready;
// writes belong in idle periods. Reset returns the engine to idle, restores
// the default timings and empties the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "onewire_bit_master_top_assert.svh"

module onewire_bit_master_top
   import owb_pkg::*;
#(
   parameter logic [TIME_W-1:0] RECOVERY_TIME = RECOVERY_TIME_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_command,
   input  logic                 req_bus_level,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_drive_low,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic                 rsp_read_bit,
   output logic                 rsp_presence,
   output logic                 rsp_rejected,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   time_type  cfg_ff [NUM_REGS];

   phase_type phase_ff, phase_in;
   op_type    op_ff, op_in;
   time_type  rem_ff, rem_in;
   logic      cap_ff, cap_in;

   logic      rsp_valid_ff;
   logic      drive_ff, busy_ff, done_ff, rbit_ff, pres_ff, rej_ff;
   logic      done_in, rbit_in, pres_in, rej_in;

   logic      req_beat;
   logic      last_tick;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= REG_RESET_VALS[i];
         end
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         cfg_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   // slot state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= OP_RESET;
         rem_ff   <= '0;
         cap_ff   <= 1'b0;
      end else if (req_beat) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         rem_ff   <= rem_in;
         cap_ff   <= cap_in;
      end
   end

   assign last_tick = (rem_ff <= TIME_W'(1));

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      rem_in   = rem_ff;
      cap_in   = cap_ff;
      done_in  = 1'b0;
      rbit_in  = 1'b0;
      pres_in  = 1'b0;
      rej_in   = 1'b0;

      unique case (req_command)
         CMD_RESET, CMD_W0, CMD_W1, CMD_READ: begin
            if (phase_ff != PH_IDLE) begin
               rej_in = 1'b1;
            end else begin
               phase_in = PH_LOW;
               cap_in   = 1'b0;
               case (req_command)
                  CMD_RESET: begin
                     op_in  = OP_RESET;
                     rem_in = ticks_of(cfg_ff[REG_RST_LOW]);
                  end
                  CMD_W0: begin
                     op_in  = OP_W0;
                     rem_in = ticks_of(cfg_ff[REG_W0_LOW]);
                  end
                  CMD_W1: begin
                     op_in  = OP_W1;
                     rem_in = ticks_of(cfg_ff[REG_W1_LOW]);
                  end
                  default: begin
                     op_in  = OP_READ;
                     rem_in = ticks_of(cfg_ff[REG_W1_LOW]);
                  end
               endcase
            end
         end
         CMD_TICK: begin
            if (phase_ff != PH_IDLE) begin
               rem_in = rem_ff - TIME_W'(1);
               if (last_tick) begin
                  unique case (phase_ff)
                     PH_LOW: begin
                        unique case (op_ff)
                           OP_W0: begin
                              phase_in = PH_TAIL;
                              rem_in   = ticks_of(cfg_ff[REG_W0_REL]);
                           end
                           OP_W1: begin
                              phase_in = PH_TAIL;
                              rem_in   = ticks_of(cfg_ff[REG_W1_REL]);
                           end
                           OP_READ: begin
                              phase_in = PH_WAIT;
                              rem_in   = ticks_of(cfg_ff[REG_RD_SAMP]);
                           end
                           default: begin
                              phase_in = PH_WAIT;
                              rem_in   = ticks_of(cfg_ff[REG_PRES_SMP]);
                           end
                        endcase
                     end
                     PH_WAIT: begin
                        cap_in   = req_bus_level;
                        phase_in = PH_TAIL;
                        rem_in   = (op_ff == OP_READ) ? ticks_of(cfg_ff[REG_RD_TAIL])
                                                      : ticks_of(RECOVERY_TIME);
                     end
                     default: begin
                        done_in  = 1'b1;
                        rbit_in  = (op_ff == OP_READ) && cap_ff;
                        pres_in  = (op_ff == OP_RESET) && !cap_ff;
                        phase_in = PH_IDLE;
                        rem_in   = '0;
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         drive_ff <= (phase_in == PH_LOW);
         busy_ff  <= (phase_in != PH_IDLE);
         done_ff  <= done_in;
         rbit_ff  <= rbit_in;
         pres_ff  <= pres_in;
         rej_ff   <= rej_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_low = drive_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_read_bit  = rbit_ff;
   assign rsp_presence  = pres_ff;
   assign rsp_rejected  = rej_ff;

   `OWB_ASSERT_COND(a_busy_count, (phase_ff == PH_IDLE) == (rem_ff == '0),
      "slot counter out of step with phase")
   `OWB_ASSERT(a_done_idle, rsp_valid_ff && done_ff |-> !busy_ff && !drive_ff,
      "done reported while slot still busy")
   `OWB_ASSERT(a_rej_busy, rsp_valid_ff && rej_ff |-> busy_ff && !done_ff,
      "reject reported on an idle engine")
   `OWB_ASSERT(a_start_low,
      req_beat && (phase_ff == PH_IDLE) && (req_command != CMD_TICK)
         && (req_command <= CMD_READ) |=> (phase_ff == PH_LOW) && rsp_valid_ff,
      "accepted start did not open a low phase")
   `OWB_ASSERT(a_drive_in_low, rsp_valid_ff && drive_ff |-> busy_ff,
      "bus driven low outside a slot")

endmodule
